/* hdl/lirv_pkg.sv */
// Shared types, constants and codes of the resampler.
`timescale 1ns / 1ps

package lirv_pkg;

  // Sample and register widths
  localparam int SAMPLE_W            = 16;
  localparam int CFG_DATA_W          = 20;
  localparam int VOL_W               = 9;
  localparam int VOL_SHIFT           = 8;
  localparam int DEF_PHASE_FRAC_BITS = 16;

  // Register reset values and limits
  localparam logic [CFG_DATA_W-1:0] STEP_RESET = CFG_DATA_W'(65536);
  localparam logic [VOL_W-1:0]      VOL_MAX    = VOL_W'(256);
  localparam logic [VOL_W-1:0]      VOL_RESET  = VOL_W'(256);

  // Longest output run for one source frame
  localparam int MAX_RUN = 64;

  // Queue depths
  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  // Input op codes
  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_END   = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  // Configuration register indexes
  typedef enum logic {
    REG_STEP_RATIO = 1'b0,
    REG_VOLUME     = 1'b1
  } cfg_reg_e;

  // Command from the front end to the back end
  typedef enum logic {
    CMD_FRAME = 1'b0,
    CMD_START = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                  kind;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } cmd_t;

  // One output word
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       last;
  } out_word_t;

endpackage

/* hdl/lirv_fifo.sv */
// Small register queue with separate push and pop sides.
`timescale 1ns / 1ps

module lirv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* hdl/lirv_front.sv */
// Front end: takes input words and config writes, drops idle items, queues commands.
`timescale 1ns / 1ps

module lirv_front #(
  parameter int PHASE_FRAC_BITS = lirv_pkg::DEF_PHASE_FRAC_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input channel
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        op_i,
  input  logic signed [lirv_pkg::SAMPLE_W-1:0] in_left_i,
  input  logic signed [lirv_pkg::SAMPLE_W-1:0] in_right_i,
  // configuration
  input  logic                              cfg_wr_en_i,
  input  logic                              cfg_index_i,
  input  logic [lirv_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // command queue
  input  logic                              cmd_full_i,
  output logic                              cmd_push_o,
  output lirv_pkg::cmd_t                    cmd_o,
  // clamped settings
  output logic [PHASE_FRAC_BITS+3:0]        step_o,
  output logic [lirv_pkg::VOL_W-1:0]        vol_o
);

  import lirv_pkg::*;

  localparam int PH_W  = PHASE_FRAC_BITS + 4;
  localparam int CMP_W = (PH_W > CFG_DATA_W) ? PH_W : CFG_DATA_W;
  localparam logic [CMP_W-1:0] STEP_MIN = CMP_W'(1) << (PHASE_FRAC_BITS - 6);
  localparam logic [CMP_W-1:0] STEP_MAX = CMP_W'(1) << (PHASE_FRAC_BITS + 3);
  localparam logic [CMP_W-1:0] STEP_RST_W = CMP_W'(STEP_RESET);
  localparam logic [CMP_W-1:0] STEP_RST_SAT =
      (STEP_RST_W < STEP_MIN) ? STEP_MIN :
      (STEP_RST_W > STEP_MAX) ? STEP_MAX : STEP_RST_W;

  logic              ended_q, ended_d;
  logic [PH_W-1:0]   step_q, step_d;
  logic [VOL_W-1:0]  vol_q, vol_d;
  logic              accept;
  logic [CMP_W-1:0]  step_raw;
  logic [CMP_W-1:0]  step_sat;
  logic [VOL_W-1:0]  vol_raw;

  assign full   = cmd_full_i;
  assign accept = push && !cmd_full_i;
  assign step_o = step_q;
  assign vol_o  = vol_q;

  // Clamp the settings as they are written
  assign step_raw = CMP_W'(cfg_data_i);
  assign step_sat = (step_raw < STEP_MIN) ? STEP_MIN :
                    (step_raw > STEP_MAX) ? STEP_MAX : step_raw;
  assign vol_raw  = cfg_data_i[VOL_W-1:0];

  always_comb begin
    step_d = step_q;
    vol_d  = vol_q;
    if (cfg_wr_en_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_STEP_RATIO: step_d = step_sat[PH_W-1:0];
        REG_VOLUME:     vol_d  = (vol_raw > VOL_MAX) ? VOL_MAX : vol_raw;
        default:        step_d = step_q;
      endcase
    end
  end

  // Classify the word: drop it while the stream is over, turn end into a zero frame
  always_comb begin
    ended_d     = ended_q;
    cmd_push_o  = 1'b0;
    cmd_o.kind  = CMD_FRAME;
    cmd_o.left  = in_left_i;
    cmd_o.right = in_right_i;
    if (accept) begin
      unique case (op_i)
        OP_START: begin
          cmd_push_o = 1'b1;
          cmd_o.kind = CMD_START;
          ended_d    = 1'b0;
        end
        OP_FRAME: begin
          cmd_push_o = !ended_q;
        end
        OP_END: begin
          cmd_push_o  = !ended_q;
          cmd_o.left  = '0;
          cmd_o.right = '0;
          ended_d     = 1'b1;
        end
        default: cmd_push_o = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ended_q <= 1'b1;
      step_q  <= STEP_RST_SAT[PH_W-1:0];
      vol_q   <= VOL_RESET;
    end else begin
      ended_q <= ended_d;
      step_q  <= step_d;
      vol_q   <= vol_d;
    end
  end

endmodule

/* hdl/lirv_back.sv */
// Back end: frame pair, phase sequencer and the interpolate/scale pipeline.
`timescale 1ns / 1ps

module lirv_back #(
  parameter int PHASE_FRAC_BITS = lirv_pkg::DEF_PHASE_FRAC_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command queue
  input  logic                        cmd_empty_i,
  input  lirv_pkg::cmd_t              cmd_i,
  output logic                        cmd_pop_o,
  // settings
  input  logic [PHASE_FRAC_BITS+3:0]  step_i,
  input  logic [lirv_pkg::VOL_W-1:0]  vol_i,
  // output queue
  input  logic                        out_full_i,
  output logic                        out_push_o,
  output lirv_pkg::out_word_t         out_word_o
);

  import lirv_pkg::*;

  localparam int PH_W   = PHASE_FRAC_BITS + 4;
  localparam int RUN_W  = $clog2(MAX_RUN);
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + PHASE_FRAC_BITS + 1;
  localparam int MUL_W  = SAMPLE_W + VOL_W + 1;
  localparam logic [PH_W-1:0]   PH_ONE    = PH_W'(1) << PHASE_FRAC_BITS;
  localparam logic [PROD_W-1:0] FRAC_MASK = (PROD_W'(1) << PHASE_FRAC_BITS) - PROD_W'(1);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    PR_NONE,
    PR_ONE,
    PR_FULL
  } prime_e;

  state_e                     state_q, state_d;
  prime_e                     primed_q, primed_d;
  logic [PH_W-1:0]            phase_q, phase_d;
  logic [RUN_W-1:0]           count_q, count_d;
  logic signed [SAMPLE_W-1:0] prev_l_q, prev_l_d, prev_r_q, prev_r_d;
  logic signed [SAMPLE_W-1:0] cur_l_q, cur_l_d, cur_r_q, cur_r_d;

  logic            advance;
  logic            issue;
  logic            issue_last;
  logic [PH_W-1:0] phase_next;
  logic [PH_W-1:0] phase_shift;

  // Pipeline registers
  logic                       v1_q, v2_q;
  logic                       last1_q, last2_q;
  logic signed [PROD_W-1:0]   prod_l_q, prod_r_q;
  logic signed [SAMPLE_W-1:0] a_l_q, a_r_q;
  logic signed [MUL_W-1:0]    mul_l_q, mul_r_q;

  logic signed [DIFF_W-1:0]   diff_l, diff_r;
  logic signed [PHASE_FRAC_BITS:0] ph_frac;
  logic signed [PROD_W-1:0]   prod_l_d, prod_r_d;
  logic signed [PROD_W-1:0]   q_l, q_r;
  logic signed [SAMPLE_W-1:0] s_l, s_r;
  logic signed [MUL_W-1:0]    mul_l_d, mul_r_d;

  // Pipeline moves when its last stage is empty or can drain
  assign advance    = !v2_q || !out_full_i;
  assign out_push_o = v2_q && !out_full_i;
  assign cmd_pop_o  = (state_q == ST_IDLE) && !cmd_empty_i;

  assign phase_next  = phase_q + step_i;
  assign issue       = (state_q == ST_EMIT) && advance;
  assign issue_last  = (phase_next >= PH_ONE) || (count_q == RUN_W'(MAX_RUN - 1));
  assign phase_shift = (phase_q >= PH_ONE) ? phase_q - PH_ONE : phase_q;

  // Sequence commands and step the phase over one output run
  always_comb begin
    state_d  = state_q;
    primed_d = primed_q;
    phase_d  = phase_q;
    count_d  = count_q;
    prev_l_d = prev_l_q;
    prev_r_d = prev_r_q;
    cur_l_d  = cur_l_q;
    cur_r_d  = cur_r_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_pop_o) begin
          if (cmd_i.kind == CMD_START) begin
            primed_d = PR_NONE;
            phase_d  = '0;
          end else if (primed_q == PR_NONE) begin
            cur_l_d  = cmd_i.left;
            cur_r_d  = cmd_i.right;
            primed_d = PR_ONE;
          end else begin
            prev_l_d = cur_l_q;
            prev_r_d = cur_r_q;
            cur_l_d  = cmd_i.left;
            cur_r_d  = cmd_i.right;
            count_d  = '0;
            if (primed_q == PR_ONE) begin
              primed_d = PR_FULL;
              state_d  = ST_EMIT;
            end else begin
              phase_d = phase_shift;
              if (phase_shift < PH_ONE) begin
                state_d = ST_EMIT;
              end
            end
          end
        end
      end
      ST_EMIT: begin
        if (issue) begin
          phase_d = phase_next;
          count_d = count_q + RUN_W'(1);
          if (issue_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      primed_q <= PR_NONE;
      phase_q  <= '0;
      count_q  <= '0;
      prev_l_q <= '0;
      prev_r_q <= '0;
      cur_l_q  <= '0;
      cur_r_q  <= '0;
    end else begin
      state_q  <= state_d;
      primed_q <= primed_d;
      phase_q  <= phase_d;
      count_q  <= count_d;
      prev_l_q <= prev_l_d;
      prev_r_q <= prev_r_d;
      cur_l_q  <= cur_l_d;
      cur_r_q  <= cur_r_d;
    end
  end

  // Stage 1: difference times phase fraction
  assign diff_l   = $signed({cur_l_q[SAMPLE_W-1], cur_l_q}) -
                    $signed({prev_l_q[SAMPLE_W-1], prev_l_q});
  assign diff_r   = $signed({cur_r_q[SAMPLE_W-1], cur_r_q}) -
                    $signed({prev_r_q[SAMPLE_W-1], prev_r_q});
  assign ph_frac  = $signed({1'b0, phase_q[PHASE_FRAC_BITS-1:0]});
  assign prod_l_d = diff_l * ph_frac;
  assign prod_r_d = diff_r * ph_frac;

  // Stage 2: shift toward zero, add the base sample, apply the gain
  assign q_l = (prod_l_q + $signed(FRAC_MASK & {PROD_W{prod_l_q[PROD_W-1]}}))
               >>> PHASE_FRAC_BITS;
  assign q_r = (prod_r_q + $signed(FRAC_MASK & {PROD_W{prod_r_q[PROD_W-1]}}))
               >>> PHASE_FRAC_BITS;
  assign s_l = a_l_q + q_l[SAMPLE_W-1:0];
  assign s_r = a_r_q + q_r[SAMPLE_W-1:0];
  assign mul_l_d = s_l * $signed({1'b0, vol_i});
  assign mul_r_d = s_r * $signed({1'b0, vol_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (advance) begin
      v1_q <= issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      prod_l_q <= prod_l_d;
      prod_r_q <= prod_r_d;
      a_l_q    <= prev_l_q;
      a_r_q    <= prev_r_q;
      last1_q  <= issue_last;
      mul_l_q  <= mul_l_d;
      mul_r_q  <= mul_r_d;
      last2_q  <= last1_q;
    end
  end

  // Floor shift by the gain scale
  assign out_word_o.left  = mul_l_q[VOL_SHIFT +: SAMPLE_W];
  assign out_word_o.right = mul_r_q[VOL_SHIFT +: SAMPLE_W];
  assign out_word_o.last  = last2_q;

  // A run only starts once the pair is primed
  a_emit_primed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> primed_q == PR_FULL)
    else $error("output run without a primed frame pair");

  // The phase stays below one for the whole run
  a_emit_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> phase_q < PH_ONE)
    else $error("phase reached one inside a run");

  // A run continues until the word marked last
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue && !issue_last |=> state_q == ST_EMIT)
    else $error("run stopped before its last word");

  // No command is taken while a run is in progress
  a_no_pop_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> !cmd_pop_o)
    else $error("command popped during a run");

endmodule

/* hdl/linear_interp_resampler_volume_top.sv */
// Top level of the linear interpolating resampler with volume.
//
// Input side is a queue: present op_i, in_left_i and in_right_i with push;
// the word is taken on a clock edge where push is high and full is low.
// op_i: frame, end of stream, start of track. Frames and end words are
// dropped until a start word arrives, and again after an end word.
// Output side is a queue: while empty is low the oldest output word is on
// out_left_o, out_right_o and run_last_o; pop takes it. run_last_o marks the
// final word that one input word produces.
// Settings go in through cfg_wr_en_i / cfg_index_i / cfg_data_i; the user
// writes them only while nothing is in flight, not enforced by the block.
// Timing: the back end loads the frame pair of a source frame, then the
// phase sequencer gives one output per cycle unless the output queue is
// full, and takes no new command until the run ends. Start and silent
// frames give no output. A stall on pop backs up the two-stage arithmetic
// pipeline and then the command queue, after which full rises.
// Reset: queues empty, step 1.0, volume unity, stream idle until a start.
`timescale 1ns / 1ps

module linear_interp_resampler_volume_top #(
  parameter int PHASE_FRAC_BITS = lirv_pkg::DEF_PHASE_FRAC_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input channel
  input  logic                                 push,
  output logic                                 full,
  input  logic [1:0]                           op_i,
  input  logic signed [lirv_pkg::SAMPLE_W-1:0] in_left_i,
  input  logic signed [lirv_pkg::SAMPLE_W-1:0] in_right_i,
  // output channel
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [lirv_pkg::SAMPLE_W-1:0] out_left_o,
  output logic signed [lirv_pkg::SAMPLE_W-1:0] out_right_o,
  output logic                                 run_last_o,
  // configuration
  input  logic                                 cfg_wr_en_i,
  input  logic                                 cfg_index_i,
  input  logic [lirv_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  import lirv_pkg::*;

  cmd_t                      cmd_in, cmd_out;
  logic                      cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [PHASE_FRAC_BITS+3:0] step;
  logic [VOL_W-1:0]          vol;
  out_word_t                 word_in, word_out;
  logic                      word_push, word_full;

  // Accept and classify input words
  lirv_front #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .op_i        (op_i),
    .in_left_i   (in_left_i),
    .in_right_i  (in_right_i),
    .cfg_wr_en_i (cfg_wr_en_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_full_i  (cmd_full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in),
    .step_o      (step),
    .vol_o       (vol)
  );

  // Decouple front and back
  lirv_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty)
  );

  // Generate interpolated, scaled words
  lirv_back #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .step_i      (step),
    .vol_i       (vol),
    .out_full_i  (word_full),
    .out_push_o  (word_push),
    .out_word_o  (word_in)
  );

  // Hold results for the receiver
  lirv_fifo #(
    .WIDTH($bits(out_word_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (word_push),
    .wdata_i (word_in),
    .full_o  (word_full),
    .pop_i   (pop),
    .rdata_o (word_out),
    .empty_o (empty)
  );

  assign out_left_o  = word_out.left;
  assign out_right_o = word_out.right;
  assign run_last_o  = word_out.last;

endmodule
